[hdl/pla_pkg.sv]
package pla_pkg;

    // Default configuration
    localparam int CHANNELS_DEF     = 6;
    localparam int WINDOW_DEF       = 5;
    localparam int EXT_CHANNELS_DEF = 4;

    // Field widths
    localparam int CH_W    = 3;
    localparam int RAW_W   = 16;
    localparam int LEVEL_W = 7;
    localparam int Q_W     = 17;

    // Unsigned Q1.16 full scale
    localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

    // External converter: ((v*4.096/32768)+0.58)/2.7 == (v+4640)/21600
    localparam logic signed [16:0] EXT_OFFSET = 17'sd4640;
    localparam logic signed [16:0] EXT_SPAN   = 17'sd21600;
    localparam logic [14:0]        EXT_DIV    = 15'd21600;
    localparam logic [30:0]        EXT_BIAS   = 31'd10800;

    // Internal converter: r/4095
    localparam logic [14:0] INT_DIV  = 15'd4095;
    localparam logic [30:0] INT_BIAS = 31'd2047;
    localparam logic [11:0] INT_MAX  = 12'd4095;

    // Reciprocals for the normalizing divide, scaled by 2^RECIP_SHIFT
    localparam int          RECIP_SHIFT = 31;
    localparam int          RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP_EXT =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd21600);
    localparam logic [RECIP_W-1:0] RECIP_INT =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd4095);

    // Output scale
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd127;

endpackage

[hdl/pla_if.sv]
// Sample channel: one raw conversion tagged with its channel
interface pla_in_if
    import pla_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         channel;
    logic signed [RAW_W-1:0] raw_sample;

    modport source (output valid, channel, raw_sample, input ready);
    modport sink   (input valid, channel, raw_sample, output ready);
endinterface

// Level channel: averaged level of one channel
interface pla_out_if
    import pla_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    out_channel;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, out_channel, level, input ready);
    modport sink   (input valid, out_channel, level, output ready);
endinterface

[hdl/multichannel_pedal_level_averager.sv]
// Windowed moving average of pedal levels over CHANNELS channels. Each sample
// item is normalized to unsigned Q1.16 (channels below EXT_CHANNELS as signed
// 16-bit external conversions, the rest as 12-bit internal conversions), stored
// in that channel's ring of WINDOW entries, and the ring's mean is returned
// scaled to 0..127 with the channel number. An item on a valid channel passes
// through MUL, FIX, WRITE, SUM, SCALE, ROUND and DONE before its result is
// loaded, and the next item is accepted only after that; the sum takes longest,
// since the single memory read port returns one ring entry per cycle. An item
// on a channel >= CHANNELS changes no ring state and goes straight to DONE,
// which loads level 0. One item is in work at a time; a finished result waits
// in the output register while the next item is accepted, and an unread result
// stalls the following one. The store reads as zero after reset through
// per-entry valid bits, so there is no clearing pass.
module multichannel_pedal_level_averager
    import pla_pkg::*;
#(
    parameter int CHANNELS     = CHANNELS_DEF,
    parameter int WINDOW       = WINDOW_DEF,
    parameter int EXT_CHANNELS = EXT_CHANNELS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    pla_in_if.sink    samples,
    pla_out_if.source levels
);

    localparam int DEPTH     = CHANNELS * WINDOW;
    localparam int AW        = $clog2(DEPTH);
    localparam int CIW       = $clog2(CHANNELS);
    localparam int SW        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = Q_W + $clog2(WINDOW);
    localparam int X_W       = SUM_W - 9;
    localparam int LVL_SHIFT = 16;
    localparam int LQ_W      = 8;
    localparam int P1_W      = 31 + RECIP_W;
    localparam int P2_W      = X_W + 17;
    localparam logic [16:0] RECIP_LVL = 17'((64'd1 << LVL_SHIFT) / WINDOW);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_FIX   = 8'b0000_0100,
        S_WRITE = 8'b0000_1000,
        S_SUM   = 8'b0001_0000,
        S_SCALE = 8'b0010_0000,
        S_ROUND = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic [SW-1:0]      write_slot_reg [CHANNELS];
    logic [SW-1:0]      write_slot_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               out_valid_reg, out_valid_next;

    // Item payload
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [CIW-1:0]     cidx_reg, cidx_next;
    logic               ext_reg, ext_next;
    logic               zero_reg, zero_next;
    logic               one_reg, one_next;
    logic [30:0]        num_reg, num_next;
    logic [P1_W-1:0]    prod_reg, prod_next;
    logic [Q_W-1:0]     q_reg, q_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [X_W-1:0]     x_reg, x_next;
    logic [P2_W-1:0]    prod2_reg, prod2_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [CH_W-1:0]    out_channel_reg, out_channel_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;

    // Sample store
    logic [Q_W-1:0]     mem [DEPTH];
    logic               vld_reg [DEPTH];
    logic [Q_W-1:0]     rd_data_reg;
    logic               rd_vld_reg;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [Q_W-1:0]     rd_word;

    // Combinational helpers
    logic               accept;
    logic               ch_ok;
    logic signed [16:0] ext_n;
    logic [11:0]        int_r;
    logic [14:0]        dvs;
    logic [Q_W-1:0]     qest;
    logic [31:0]        qd;
    logic [31:0]        norm_rem;
    logic [SUM_W+6:0]   scaled;
    logic [LQ_W-1:0]    lq_est;
    logic [X_W-1:0]     lvl_rem;
    logic [LQ_W-1:0]    lq;

    assign samples.ready     = (state_reg == S_IDLE);
    assign accept            = samples.valid && samples.ready;
    assign ch_ok             = 32'(samples.channel) < 32'(CHANNELS);
    assign levels.valid      = out_valid_reg;
    assign levels.out_channel = out_channel_reg;
    assign levels.level      = out_level_reg;

    // Memory port control
    assign wr_en   = (state_reg == S_WRITE);
    assign wr_addr = base_reg + AW'(slot_reg);
    assign rd_en   = (state_reg == S_SUM) && (32'(rd_cnt_reg) < 32'(WINDOW));
    assign rd_addr = base_reg + AW'(rd_cnt_reg);
    assign rd_word = rd_vld_reg ? rd_data_reg : '0;

    // Normalizer front end: offset, saturation, numerator
    assign ext_n = $signed({samples.raw_sample[RAW_W-1], samples.raw_sample}) + EXT_OFFSET;

    always_comb
    begin
        if (samples.raw_sample < 0)
            int_r = '0;
        else if (samples.raw_sample > $signed({4'd0, INT_MAX}))
            int_r = INT_MAX;
        else
            int_r = samples.raw_sample[11:0];
    end

    // Reciprocal estimate correction (estimate is low by at most one)
    assign dvs      = ext_reg ? EXT_DIV : INT_DIV;
    assign qest     = prod_reg[RECIP_SHIFT +: Q_W];
    assign qd       = 32'(qest) * 32'(dvs);
    assign norm_rem = 32'(num_reg) - qd;

    // Level scaling: x = floor(sum*127 / 2^16), then x / WINDOW
    assign scaled  = {sum_reg, 7'd0} - (SUM_W+7)'(sum_reg);
    assign lq_est  = prod2_reg[LVL_SHIFT +: LQ_W];
    assign lvl_rem = x_reg - X_W'(lq_est) * X_W'(WINDOW);
    assign lq      = (lvl_rem >= X_W'(WINDOW)) ? lq_est + LQ_W'(1) : lq_est;

    // Next-state and datapath
    always_comb
    begin
        state_next       = state_reg;
        write_slot_next  = slot_reg;
        rd_cnt_next      = rd_cnt_reg;
        rd_pend_next     = rd_en;
        out_valid_next   = out_valid_reg && !levels.ready;
        ch_next          = ch_reg;
        cidx_next        = cidx_reg;
        ext_next         = ext_reg;
        zero_next        = zero_reg;
        one_next         = one_reg;
        num_next         = num_reg;
        prod_next        = prod_reg;
        q_next           = q_reg;
        base_next        = base_reg;
        slot_next        = slot_reg;
        sum_next         = sum_reg;
        x_next           = x_reg;
        prod2_next       = prod2_reg;
        level_next       = level_reg;
        out_channel_next = out_channel_reg;
        out_level_next   = out_level_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next   = samples.channel;
                    cidx_next = CIW'(samples.channel);
                    ext_next  = 32'(samples.channel) < 32'(EXT_CHANNELS);
                    if (ext_next)
                    begin
                        zero_next = (ext_n <= 0);
                        one_next  = (ext_n >= EXT_SPAN);
                        if (zero_next || one_next)
                            num_next = '0;
                        else
                            num_next = {ext_n[14:0], 16'd0} + EXT_BIAS;
                    end
                    else
                    begin
                        zero_next = 1'b0;
                        one_next  = 1'b0;
                        num_next  = {3'd0, int_r, 16'd0} + INT_BIAS;
                    end
                    if (ch_ok)
                        state_next = S_MUL;
                    else
                    begin
                        level_next = '0;
                        state_next = S_DONE;
                    end
                end
            end

            S_MUL:
            begin
                prod_next  = P1_W'(num_reg) * P1_W'(ext_reg ? RECIP_EXT : RECIP_INT);
                base_next  = AW'(cidx_reg) * AW'(WINDOW);
                slot_next  = write_slot_reg[cidx_reg];
                state_next = S_FIX;
            end

            S_FIX:
            begin
                if (zero_reg)
                    q_next = '0;
                else if (one_reg)
                    q_next = Q_ONE;
                else if (norm_rem >= 32'(dvs))
                    q_next = qest + Q_W'(1);
                else
                    q_next = qest;
                state_next = S_WRITE;
            end

            S_WRITE:
            begin
                if (32'(slot_reg) + 32'd1 >= 32'(WINDOW))
                    write_slot_next = '0;
                else
                    write_slot_next = slot_reg + SW'(1);
                rd_cnt_next = '0;
                sum_next    = '0;
                state_next  = S_SUM;
            end

            S_SUM:
            begin
                if (rd_en)
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                if (rd_pend_reg)
                    sum_next = sum_reg + SUM_W'(rd_word);
                if (32'(rd_cnt_reg) == 32'(WINDOW))
                    state_next = S_SCALE;
            end

            S_SCALE:
            begin
                x_next     = scaled[SUM_W+6:LVL_SHIFT];
                prod2_next = P2_W'(x_next) * P2_W'(RECIP_LVL);
                state_next = S_ROUND;
            end

            S_ROUND:
            begin
                if (lq > LQ_W'(LEVEL_MAX))
                    level_next = LEVEL_MAX;
                else
                    level_next = lq[LEVEL_W-1:0];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || levels.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_channel_next = ch_reg;
                    out_level_next   = level_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                write_slot_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_WRITE)
                write_slot_reg[cidx_reg] <= write_slot_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ch_reg          <= ch_next;
        cidx_reg        <= cidx_next;
        ext_reg         <= ext_next;
        zero_reg        <= zero_next;
        one_reg         <= one_next;
        num_reg         <= num_next;
        prod_reg        <= prod_next;
        q_reg           <= q_next;
        base_reg        <= base_next;
        slot_reg        <= slot_next;
        sum_reg         <= sum_next;
        x_reg           <= x_next;
        prod2_reg       <= prod2_next;
        level_reg       <= level_next;
        out_channel_reg <= out_channel_next;
        out_level_reg   <= out_level_next;
    end

    // Entry valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Sample store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= q_reg;
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    // Checks
    a_norm_within_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX) && !zero_reg && !one_reg |-> norm_rem < (32'(dvs) << 1))
        else $error("normalizer reciprocal estimate off by more than one");

    a_level_within_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> lvl_rem < X_W'(2 * WINDOW))
        else $error("level reciprocal estimate off by more than one");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> (32'(slot_reg) < 32'(WINDOW)) && (q_reg <= Q_ONE))
        else $error("ring slot or normalized value out of range");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCALE) |-> 32'(sum_reg) <= 32'(WINDOW) * 32'(Q_ONE))
        else $error("window sum exceeds full scale");

    a_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !ch_ok |=> (state_reg == S_DONE) && (level_reg == '0))
        else $error("out-of-range channel not reported as zero");

endmodule

[tb/multichannel_pedal_level_averager_tb.sv]
`timescale 1ns / 1ps

module multichannel_pedal_level_averager_tb;
    import pla_pkg::*;

    localparam int CHANNELS     = CHANNELS_DEF;
    localparam int WINDOW       = WINDOW_DEF;
    localparam int EXT_CHANNELS = EXT_CHANNELS_DEF;

    // Normalization constants: external (v + 4640) / 21600, internal r / 4095
    localparam int          EXT_ZERO_SHIFT = 4640;
    localparam int          EXT_FULL_SPAN  = 21600;
    localparam int          INT_FULL_CODE  = 4095;
    localparam longint      Q16_ONE        = 65536;
    localparam int          LEVEL_TOP      = 127;

    // Raw codes that sit on the external clamp points
    localparam logic signed [RAW_W-1:0] EXT_RAW_ZERO = -16'sd4640;
    localparam logic signed [RAW_W-1:0] EXT_RAW_FULL = 16'sd16960;

    localparam int  PIPE_CYCLES = WINDOW + 8;
    localparam int  CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [LEVEL_W-1:0] level;
    } level_item_t;

    logic clk;
    logic rst_n;

    pla_in_if  samples_if ();
    pla_out_if levels_if ();

    multichannel_pedal_level_averager #(
        .CHANNELS     (CHANNELS),
        .WINDOW       (WINDOW),
        .EXT_CHANNELS (EXT_CHANNELS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if.sink),
        .levels  (levels_if.source)
    );

    // Shadow of the per-channel rings
    logic [Q_W-1:0] ring_entry [CHANNELS][WINDOW];
    int             ring_slot  [CHANNELS];

    level_item_t pending_levels [$];

    int error_count;
    int items_sent;
    int levels_checked;
    int bad_channel_items;
    int full_scale_levels;
    int cycle_count;
    int burst_left;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d levels outstanding",
                     cycle_count, pending_levels.size());
            $display("multichannel_pedal_level_averager_tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Raw code to unsigned Q1.16, rounded to nearest
    function automatic logic [Q_W-1:0] raw_to_q16(input logic [CH_W-1:0] ch,
                                                  input logic signed [RAW_W-1:0] raw);
        int     n;
        int     r;
        longint num;
        if (ch < EXT_CHANNELS)
        begin
            n = int'(raw) + EXT_ZERO_SHIFT;
            if (n <= 0)
                return '0;
            if (n >= EXT_FULL_SPAN)
                return Q_W'(Q16_ONE);
            num = longint'(n) * Q16_ONE + EXT_FULL_SPAN / 2;
            return Q_W'(num / EXT_FULL_SPAN);
        end
        r = int'(raw);
        if (r < 0)
            r = 0;
        else if (r > INT_FULL_CODE)
            r = INT_FULL_CODE;
        num = longint'(r) * Q16_ONE + INT_FULL_CODE / 2;
        return Q_W'(num / INT_FULL_CODE);
    endfunction

    // Store the sample in its ring and work out the averaged level
    function automatic level_item_t average_after_sample(input logic [CH_W-1:0] ch,
                                                         input logic signed [RAW_W-1:0] raw);
        level_item_t res;
        longint      ring_sum;
        longint      lvl;
        res.ch    = ch;
        res.level = '0;
        if (ch >= CHANNELS)
            return res;
        ring_entry[ch][ring_slot[ch]] = raw_to_q16(ch, raw);
        ring_slot[ch] = (ring_slot[ch] + 1 >= WINDOW) ? 0 : ring_slot[ch] + 1;
        ring_sum = 0;
        for (int i = 0; i < WINDOW; i++)
            ring_sum += ring_entry[ch][i];
        lvl = (ring_sum * LEVEL_TOP) / (longint'(WINDOW) * Q16_ONE);
        if (lvl > LEVEL_TOP)
            lvl = LEVEL_TOP;
        res.level = LEVEL_W'(lvl);
        return res;
    endfunction

    // Sender pacing: random bursts separated by random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        for (int k = 0; k < gap; k++)
        begin
            @(negedge clk);
            samples_if.valid = 1'b0;
        end
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8);
    endtask

    // Send one sample item and record the level it should produce
    task automatic send_sample(input logic [CH_W-1:0] ch,
                               input logic signed [RAW_W-1:0] raw);
        pace_sender();
        @(negedge clk);
        samples_if.valid      = 1'b1;
        samples_if.channel    = ch;
        samples_if.raw_sample = raw;
        do
            @(posedge clk);
        while (!samples_if.ready);
        pending_levels.push_back(average_after_sample(ch, raw));
        items_sent++;
        if (ch >= CHANNELS)
            bad_channel_items++;
    endtask

    // Hold the sender off until every expected level has come back
    task automatic wait_for_drain();
        @(negedge clk);
        samples_if.valid = 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: alternating runs of ready and stalls of varying depth
    int ready_run;
    int stall_run;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            levels_if.ready = 1'b0;
            ready_run = 0;
            stall_run = 0;
        end
        else if (stall_run > 0)
        begin
            levels_if.ready = 1'b0;
            stall_run--;
        end
        else if (ready_run > 0)
        begin
            levels_if.ready = 1'b1;
            ready_run--;
        end
        else
        begin
            levels_if.ready = 1'b1;
            ready_run = $urandom_range(0, 30);
            case ($urandom_range(0, 3))
                0:       stall_run = 0;
                1:       stall_run = $urandom_range(10, 25);
                default: stall_run = $urandom_range(1, 4);
            endcase
        end
    end

    // Compare each level item with the oldest expectation
    always @(posedge clk)
    begin : check_levels
        level_item_t want;
        if (rst_n && levels_if.valid && levels_if.ready)
        begin
            if (pending_levels.size() == 0)
                report_mismatch($sformatf("unexpected level item ch=%0d level=%0d",
                                          levels_if.out_channel, levels_if.level));
            else
            begin
                want = pending_levels.pop_front();
                if (levels_if.out_channel !== want.ch)
                    report_mismatch($sformatf("out_channel got %0d want %0d",
                                              levels_if.out_channel, want.ch));
                if (levels_if.level !== want.level)
                    report_mismatch($sformatf("level on ch %0d got %0d want %0d",
                                              want.ch, levels_if.level, want.level));
                levels_checked++;
                if (want.level == LEVEL_MAX)
                    full_scale_levels++;
            end
        end
    end

    // Random raw code suited to the channel kind
    function automatic logic signed [RAW_W-1:0] random_raw(input logic [CH_W-1:0] ch);
        int sel;
        sel = $urandom_range(0, 9);
        if (ch < EXT_CHANNELS)
        begin
            if (sel < 3)
                return RAW_W'($urandom);
            if (sel < 8)
                return RAW_W'(int'($urandom_range(0, EXT_FULL_SPAN)) - EXT_ZERO_SHIFT);
            if (sel == 8)
                return EXT_RAW_ZERO + RAW_W'(int'($urandom_range(0, 6)) - 3);
            return EXT_RAW_FULL + RAW_W'(int'($urandom_range(0, 6)) - 3);
        end
        if (ch < CHANNELS && sel < 8)
            return RAW_W'($urandom_range(0, INT_FULL_CODE));
        return RAW_W'($urandom);
    endfunction

    // First samples land in rings that read as zero
    task automatic test_empty_rings();
        send_sample(3'd0, EXT_RAW_FULL);
        send_sample(3'd4, 16'sd4095);
    endtask

    // External clamp points, rounding just above zero, wrap of the ring
    task automatic test_external_range();
        send_sample(3'd1, -16'sd32768);
        send_sample(3'd1, EXT_RAW_ZERO);
        send_sample(3'd1, EXT_RAW_ZERO + 16'sd1);
        send_sample(3'd1, EXT_RAW_FULL - 16'sd1);
        send_sample(3'd1, EXT_RAW_FULL);
        send_sample(3'd1, 16'sd32767);
        send_sample(3'd1, 16'sd0);
    endtask

    // Internal codes outside 0..4095 saturate
    task automatic test_internal_saturation();
        send_sample(3'd5, -16'sd1);
        send_sample(3'd5, 16'sd0);
        send_sample(3'd5, 16'sd4096);
        send_sample(3'd5, 16'sd32767);
        send_sample(3'd5, 16'sd2048);
        send_sample(3'd4, 16'sd1);
    endtask

    // Channels past the last one report level 0 and touch nothing
    task automatic test_bad_channel();
        send_sample(3'd6, 16'sd100);
        send_sample(3'd7, -16'sd1);
    endtask

    // A full ring at full scale gives the top level, then one low sample
    task automatic test_full_scale();
        for (int i = 0; i < WINDOW; i++)
            send_sample(3'd3, EXT_RAW_FULL);
        send_sample(3'd3, -16'sd32768);
    endtask

    // Mixed traffic: held pedal positions on one channel plus scattered items
    task automatic test_random_traffic(input int count);
        int                        done;
        int                        run;
        int                        target;
        logic [CH_W-1:0]           ch;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                ch  = CH_W'($urandom_range(0, CHANNELS - 1));
                run = $urandom_range(WINDOW, 2 * WINDOW);
                if (ch < EXT_CHANNELS)
                    target = int'($urandom_range(0, EXT_FULL_SPAN)) - EXT_ZERO_SHIFT;
                else
                    target = $urandom_range(0, INT_FULL_CODE);
                for (int i = 0; i < run; i++)
                    send_sample(ch, RAW_W'(target + int'($urandom_range(0, 100)) - 50));
                done += run;
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    ch = CH_W'($urandom_range(CHANNELS, (1 << CH_W) - 1));
                else
                    ch = CH_W'($urandom_range(0, CHANNELS - 1));
                send_sample(ch, random_raw(ch));
                done++;
            end
        end
    endtask

    // Sender holds off until the block has returned everything
    task automatic test_drain_pause();
        wait_for_drain();
        send_sample(3'd2, RAW_W'($urandom));
        wait_for_drain();
    endtask

    initial
    begin
        error_count       = 0;
        items_sent        = 0;
        levels_checked    = 0;
        bad_channel_items = 0;
        full_scale_levels = 0;
        burst_left        = 0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            ring_slot[c] = 0;
            for (int i = 0; i < WINDOW; i++)
                ring_entry[c][i] = '0;
        end

        rst_n                 = 1'b0;
        samples_if.valid      = 1'b0;
        samples_if.channel    = '0;
        samples_if.raw_sample = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_rings();
        test_external_range();
        test_internal_saturation();
        test_bad_channel();
        test_full_scale();
        test_random_traffic(350);
        test_drain_pause();
        test_random_traffic(350);

        // Drain, then let the pipeline settle
        @(negedge clk);
        samples_if.valid = 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (4 * PIPE_CYCLES) @(posedge clk);

        if (pending_levels.size() != 0)
            report_mismatch($sformatf("%0d level items never arrived",
                                      pending_levels.size()));

        $display("run covered %0d sample items (%0d on unused channels), %0d levels checked",
                 items_sent, bad_channel_items, levels_checked);
        $display("full-scale levels seen: %0d, mismatches: %0d",
                 full_scale_levels, error_count);
        if (error_count == 0)
            $display("multichannel_pedal_level_averager_tb: clean");
        else
            $display("multichannel_pedal_level_averager_tb: errors");
        $finish;
    end

endmodule

[multichannel_pedal_level_averager.f]
hdl/pla_pkg.sv
hdl/pla_if.sv
hdl/multichannel_pedal_level_averager.sv
tb/multichannel_pedal_level_averager_tb.sv
